// ----- hw/rtl/sbl_pkg.sv -----
package sbl_pkg;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [1:0] KIND_WRITE     = 2'd0;
  localparam logic [1:0] KIND_JUMP      = 2'd1;
  localparam logic [1:0] KIND_BAD_TYPE  = 2'd2;
  localparam logic [1:0] KIND_BAD_XFER  = 2'd3;

  localparam logic [7:0]  TYPE_DATA = 8'd0;
  localparam logic [7:0]  TYPE_END  = 8'd255;
  localparam logic [15:0] MAX_XFER  = 16'd32767;

  localparam logic [2:0] HDR_TYPE    = 3'd0;
  localparam logic [2:0] HDR_LEN_HI  = 3'd1;
  localparam logic [2:0] HDR_LEN_LO  = 3'd2;
  localparam logic [2:0] HDR_ADDR_HI = 3'd3;
  localparam logic [2:0] HDR_ADDR_LO = 3'd4;

  localparam int OBUF_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] target_address;
    logic [7:0]  write_data;
  } result_t;

endpackage

// ----- hw/rtl/sbl_parse.sv -----
module sbl_parse
  import sbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] file_byte,
  input  logic       restart,
  output logic       res_valid,
  output result_t    res
);

  logic [1:0]  phase, phase_next;
  logic [2:0]  header_index, header_index_next;
  logic [7:0]  block_type, block_type_next;
  logic [15:0] remaining_length, remaining_length_next;
  logic [15:0] load_address, load_address_next;

  always_comb begin
    logic [1:0] ph;
    logic [2:0] hi;
    ph = restart ? PH_HEADER : phase;
    hi = restart ? HDR_TYPE : header_index;
    phase_next            = ph;
    header_index_next     = hi;
    block_type_next       = block_type;
    remaining_length_next = remaining_length;
    load_address_next     = load_address;
    res_valid             = 1'b0;
    res                   = '0;
    if (ph == PH_DATA) begin
      load_address_next     = load_address + 16'd1;
      remaining_length_next = remaining_length - 16'd1;
      if (remaining_length == 16'd1) begin
        phase_next = PH_HEADER;
      end
      res_valid          = 1'b1;
      res.kind           = KIND_WRITE;
      res.target_address = load_address;
      res.write_data     = file_byte;
    end else if (ph == PH_HEADER) begin
      unique case (hi)
        HDR_TYPE:    block_type_next = file_byte;
        HDR_LEN_HI:  remaining_length_next = {file_byte, 8'd0};
        HDR_LEN_LO:  remaining_length_next = {remaining_length[15:8], file_byte};
        HDR_ADDR_HI: load_address_next = {file_byte, 8'd0};
        default:     load_address_next = {load_address[15:8], file_byte};
      endcase
      if (hi < HDR_ADDR_LO) begin
        header_index_next = hi + 3'd1;
      end else begin
        header_index_next = HDR_TYPE;
        if (block_type == TYPE_DATA) begin
          if (remaining_length != 16'd0) begin
            phase_next = PH_DATA;
          end
        end else begin
          phase_next = PH_DONE;
          res_valid  = 1'b1;
          if (block_type == TYPE_END) begin
            if (load_address_next == 16'd0 || load_address_next > MAX_XFER ||
                remaining_length != 16'd0) begin
              res.kind = KIND_BAD_XFER;
            end else begin
              res.kind           = KIND_JUMP;
              res.target_address = load_address_next;
            end
          end else begin
            res.kind = KIND_BAD_TYPE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      header_index     <= HDR_TYPE;
      block_type       <= '0;
      remaining_length <= '0;
      load_address     <= '0;
    end else if (step) begin
      phase            <= phase_next;
      header_index     <= header_index_next;
      block_type       <= block_type_next;
      remaining_length <= remaining_length_next;
      load_address     <= load_address_next;
    end
  end

`ifndef SYNTHESIS
  a_hdr_index_range: assert property (@(posedge clk) disable iff (rst)
    header_index <= HDR_ADDR_LO)
    else $error("header index out of range");

  a_data_has_length: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> remaining_length != 16'd0)
    else $error("data phase with zero remaining length");

  a_final_goes_done: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.kind != KIND_WRITE |=> phase == PH_DONE)
    else $error("jump or error did not end the file");
`endif

endmodule

// ----- hw/rtl/sbl_obuf.sv -----
module sbl_obuf
  import sbl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_item,
  output logic    full,
  output logic    out_valid,
  input  logic    pop,
  output result_t out_item
);

  logic [1:0] count, count_next;
  result_t    ent0, ent1;

  assign full      = (count == 2'(OBUF_DEPTH));
  assign out_valid = (count != 2'd0);
  assign out_item  = ent0;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        ent0 <= push_item;
      end else begin
        ent0 <= ent1;
        ent1 <= push_item;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        ent0 <= push_item;
      end else begin
        ent1 <= push_item;
      end
    end else if (pop) begin
      ent0 <= ent1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !full)
    else $error("push into full result buffer");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0)
    else $error("pop from empty result buffer");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("result count did not advance on push");
`endif

endmodule

// ----- hw/rtl/segmented_binary_loader.sv -----
// Segmented binary loader: parses a machine-language binary one byte per item.
// Input channel s_*: one file byte per item; s_tuser[0] marks the first byte
// of a new file and restarts parsing at a segment header.
// Output channel m_*: zero or one result per input byte; m_tuser is the kind
// (memory write, jump, bad block type, bad transfer), m_tdata carries the
// target address and the data byte of a memory write.
// Throughput: one byte per cycle while the result buffer is not full; the parse
// step lies between the input register and the two-entry result buffer.
// A result passes the input register and the parse step into the result buffer, which offers it on m_tvalid.
// Reset clears the parser to the header of a new file and empties both the
// input register and the result buffer.
// When the receiver stalls, results collect in the two-entry buffer; once it
// is full and a byte waits in the input register, s_tready drops until the
// receiver takes a result. No result is lost or repeated.
// After a jump or an error every byte is consumed without a result until a
// byte arrives with the restart flag.
module segmented_binary_loader
  import sbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] file_byte
  input  logic [0:0]  s_tuser,   // [0] restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] target_address, [23:16] write_data
  output logic [1:0]  m_tuser    // [1:0] kind
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_restart;
  logic       full;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_item;

  assign advance  = in_valid && !full;
  assign s_tready = !(in_valid && full);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte    <= s_tdata;
      in_restart <= s_tuser[0];
    end
  end

  sbl_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .file_byte (in_byte),
    .restart   (in_restart),
    .res_valid (res_valid),
    .res       (res)
  );

  sbl_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && res_valid),
    .push_item (res),
    .full      (full),
    .out_valid (m_tvalid),
    .pop       (m_tvalid && m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = {out_item.write_data, out_item.target_address};
  assign m_tuser = out_item.kind;

endmodule
